/* hdl/maxwell_tent_inverse_map_assert.svh */
// assertion macros for the tent inverse map checks
// expects clk and arst_n in the scope of use
`ifndef MAXWELL_TENT_INVERSE_MAP_ASSERT_SVH
`define MAXWELL_TENT_INVERSE_MAP_ASSERT_SVH

// same-cycle implication
`define MTIM_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTIM_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mtim_pkg.sv */
// shared types and constants for the tent inverse map datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtim_pkg;

	localparam int LANES = 6;
	localparam int DIV_STEPS = 32;

	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic        valid;
		logic        flag;
	} ctrl_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] low;
		logic [31:0] quo;
		logic        neg;
		logic        ovf;
	} lane_t;

endpackage

`default_nettype wire

/* hdl/maxwell_tent_inverse_map.sv */
// top level of the tent inverse map: products, sums, numerators, divider, saturation
// depends on mtim_pkg, mtim_div_stage and maxwell_tent_inverse_map_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "maxwell_tent_inverse_map_assert.svh"

// Takes one item per cycle when out_ready stays high. Five stages form the
// gradient products, the sums, the numerators and their magnitudes, one stage
// checks quotient overflow, and a 32-stage restoring divider (one quotient bit
// per stage) forms the quotient. The whole pipeline advances when the output
// register is empty or taken; a one-item skid register at the input keeps
// in_ready a registered signal. near_singular uses the margin register value
// at the time the item passes the sum stage; write singular_margin only while
// the block is idle.
module maxwell_tent_inverse_map (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [29:0]        singular_margin,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] grad_x,
	input  wire logic signed [31:0] grad_y,
	input  wire logic signed [31:0] grad_z,
	input  wire logic signed [31:0] in_e_x,
	input  wire logic signed [31:0] in_e_y,
	input  wire logic signed [31:0] in_e_z,
	input  wire logic signed [31:0] in_h_x,
	input  wire logic signed [31:0] in_h_y,
	input  wire logic signed [31:0] in_h_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      out_e_x,
	output logic signed [31:0]      out_e_y,
	output logic signed [31:0]      out_e_z,
	output logic signed [31:0]      out_h_x,
	output logic signed [31:0]      out_h_y,
	output logic signed [31:0]      out_h_z,
	output logic                    near_singular
);

	localparam int L = mtim_pkg::LANES;
	localparam int N = mtim_pkg::DIV_STEPS;

	logic [29:0] margin_q;
	logic        en;

	// input skid
	logic               skid_full_q;
	logic signed [31:0] skid_g_q [3];
	logic signed [31:0] skid_u_q [L];
	logic               src_valid;
	logic signed [31:0] src_g [3];
	logic signed [31:0] src_u [L];

	// stage 1
	logic               v_s1;
	logic signed [31:0] g_s1 [3];
	logic signed [31:0] u_s1 [L];
	logic signed [63:0] sq_s1 [3];
	logic signed [63:0] pu_s1 [L];
	logic signed [63:0] xp_s1 [L];
	logic signed [63:0] xn_s1 [L];

	// stage 2
	logic               v_s2;
	logic signed [31:0] g_s2 [3];
	logic signed [31:0] u_s2 [L];
	logic signed [65:0] pe_s2;
	logic signed [65:0] ph_s2;
	logic signed [64:0] x_s2 [L];
	logic [63:0]        dm_s2;
	logic               dneg_s2;
	logic               flag_s2;
	logic [63:0]        s_sum;

	// stage 3
	logic               v_s3;
	logic signed [31:0] u_s3 [L];
	logic signed [64:0] x_s3 [L];
	logic signed [64:0] mh_s3 [L];
	logic signed [65:0] ml_s3 [L];
	logic [63:0]        dm_s3;
	logic               dneg_s3;
	logic               flag_s3;

	// stage 4
	logic               v_s4;
	logic signed [97:0] num_s4 [L];
	logic [63:0]        dm_s4;
	logic               dneg_s4;
	logic               flag_s4;

	// stage 5
	logic               v_s5;
	logic [95:0]        mag_s5 [L];
	logic               qneg_s5 [L];
	logic [63:0]        dm_s5;
	logic               flag_s5;

	// divider chain, entry 0 is the overflow check stage
	mtim_pkg::ctrl_t                 div_ctrl [N+1];
	logic [63:0]                     div_dm [N+1];
	mtim_pkg::lane_t [L-1:0]         div_lane [N+1];

	// output register
	logic        out_valid_q;
	logic [31:0] res_q [L];
	logic        flag_q;

	assign cfg_ready = 1'b1;
	assign en = !out_valid_q || out_ready;
	assign in_ready = !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 30'd11;
		end else if (cfg_valid && cfg_ready) begin
			margin_q <= singular_margin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready) begin
			skid_g_q[0] <= grad_x;
			skid_g_q[1] <= grad_y;
			skid_g_q[2] <= grad_z;
			skid_u_q[0] <= in_e_x;
			skid_u_q[1] <= in_e_y;
			skid_u_q[2] <= in_e_z;
			skid_u_q[3] <= in_h_x;
			skid_u_q[4] <= in_h_y;
			skid_u_q[5] <= in_h_z;
		end
	end

	always_comb begin
		src_valid = skid_full_q || in_valid;
		if (skid_full_q) begin
			src_g = skid_g_q;
			src_u = skid_u_q;
		end else begin
			src_g[0] = grad_x;
			src_g[1] = grad_y;
			src_g[2] = grad_z;
			src_u[0] = in_e_x;
			src_u[1] = in_e_y;
			src_u[2] = in_e_z;
			src_u[3] = in_h_x;
			src_u[4] = in_h_y;
			src_u[5] = in_h_z;
		end
	end

	// valid chain for the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: all 32 by 32 products
	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= src_g;
			u_s1 <= src_u;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= src_g[i] * src_g[i];
			end
			for (int j = 0; j < L; j++) begin
				pu_s1[j] <= src_g[j % 3] * src_u[j];
			end
			xp_s1[0] <= src_g[1] * src_u[5];
			xn_s1[0] <= src_g[2] * src_u[4];
			xp_s1[1] <= src_g[2] * src_u[3];
			xn_s1[1] <= src_g[0] * src_u[5];
			xp_s1[2] <= src_g[0] * src_u[4];
			xn_s1[2] <= src_g[1] * src_u[3];
			xp_s1[3] <= src_g[2] * src_u[1];
			xn_s1[3] <= src_g[1] * src_u[2];
			xp_s1[4] <= src_g[0] * src_u[2];
			xn_s1[4] <= src_g[2] * src_u[0];
			xp_s1[5] <= src_g[1] * src_u[0];
			xn_s1[5] <= src_g[0] * src_u[1];
		end
	end

	// stage 2: dot products, cross terms, norm and denominator
	assign s_sum = $unsigned(sq_s1[0]) + $unsigned(sq_s1[1]) + $unsigned(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2 <= g_s1;
			u_s2 <= u_s1;
			pe_s2 <= 66'(pu_s1[0]) + 66'(pu_s1[1]) + 66'(pu_s1[2]);
			ph_s2 <= 66'(pu_s1[3]) + 66'(pu_s1[4]) + 66'(pu_s1[5]);
			for (int r = 0; r < L; r++) begin
				x_s2[r] <= 65'(xp_s1[r]) - 65'(xn_s1[r]);
			end
			if (s_sum >= mtim_pkg::ONE_Q60) begin
				dm_s2 <= s_sum - mtim_pkg::ONE_Q60;
				dneg_s2 <= 1'b0;
			end else begin
				dm_s2 <= mtim_pkg::ONE_Q60 - s_sum;
				dneg_s2 <= 1'b1;
			end
			flag_s2 <= ({1'b0, s_sum} + {5'd0, margin_q, 30'd0}) > {1'b0, mtim_pkg::ONE_Q60};
		end
	end

	// stage 3: gradient times dot product, split into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			u_s3 <= u_s2;
			x_s3 <= x_s2;
			dm_s3 <= dm_s2;
			dneg_s3 <= dneg_s2;
			flag_s3 <= flag_s2;
			for (int r = 0; r < 3; r++) begin
				mh_s3[r] <= g_s2[r] * $signed(pe_s2[65:33]);
				ml_s3[r] <= g_s2[r] * $signed({1'b0, pe_s2[32:0]});
				mh_s3[r+3] <= g_s2[r] * $signed(ph_s2[65:33]);
				ml_s3[r+3] <= g_s2[r] * $signed({1'b0, ph_s2[32:0]});
			end
		end
	end

	// stage 4: numerators
	always_ff @(posedge clk) begin
		if (en) begin
			dm_s4 <= dm_s3;
			dneg_s4 <= dneg_s3;
			flag_s4 <= flag_s3;
			for (int r = 0; r < L; r++) begin
				num_s4[r] <= (98'(mh_s3[r]) <<< 33) + 98'(ml_s3[r])
					- (98'(u_s3[r]) <<< 60) + (98'(x_s3[r]) <<< 30);
			end
		end
	end

	// stage 5: magnitude and quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			dm_s5 <= dm_s4;
			flag_s5 <= flag_s4;
			for (int r = 0; r < L; r++) begin
				mag_s5[r] <= num_s4[r][97] ? 96'(-num_s4[r]) : 96'(num_s4[r]);
				qneg_s5[r] <= num_s4[r][97] ^ dneg_s4;
			end
		end
	end

	// overflow check: quotient of 2^32 or more saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_ctrl[0] <= '0;
		end else if (en) begin
			div_ctrl[0].valid <= v_s5;
			div_ctrl[0].flag <= flag_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_dm[0] <= dm_s5;
			for (int r = 0; r < L; r++) begin
				div_lane[0][r].rem <= mag_s5[r][95:32];
				div_lane[0][r].low <= mag_s5[r][31:0];
				div_lane[0][r].quo <= '0;
				div_lane[0][r].neg <= qneg_s5[r];
				div_lane[0][r].ovf <= mag_s5[r][95:32] >= dm_s5;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		mtim_div_stage u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_d (div_ctrl[k]),
			.dm_d   (div_dm[k]),
			.lane_d (div_lane[k]),
			.ctrl_q (div_ctrl[k+1]),
			.dm_q   (div_dm[k+1]),
			.lane_q (div_lane[k+1])
		);
	end

	// output register with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_ctrl[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_q <= div_ctrl[N].flag;
			for (int r = 0; r < L; r++) begin
				priority if (div_lane[N][r].ovf) begin
					res_q[r] <= div_lane[N][r].neg ? mtim_pkg::SAT_NEG : mtim_pkg::SAT_POS;
				end else if (div_lane[N][r].neg) begin
					res_q[r] <= (div_lane[N][r].quo > mtim_pkg::SAT_NEG) ? mtim_pkg::SAT_NEG
						: -div_lane[N][r].quo;
				end else begin
					res_q[r] <= div_lane[N][r].quo[31] ? mtim_pkg::SAT_POS
						: div_lane[N][r].quo;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_e_x = $signed(res_q[0]);
	assign out_e_y = $signed(res_q[1]);
	assign out_e_z = $signed(res_q[2]);
	assign out_h_x = $signed(res_q[3]);
	assign out_h_y = $signed(res_q[4]);
	assign out_h_z = $signed(res_q[5]);
	assign near_singular = flag_q;

	`MTIM_CHECK_NEXT(a_skid_hold, skid_full_q && !en, skid_full_q, "skid item lost while stalled")
	`MTIM_CHECK_NEXT(a_skid_fill, in_valid && in_ready && !en, skid_full_q, "stalled item not kept")
	`MTIM_CHECK_NEXT(a_bubble, en && !src_valid, !v_s1, "bubble turned into an item")
	`MTIM_CHECK_NEXT(a_ovf_sat,
		en && div_ctrl[N].valid && div_lane[N][0].ovf && !div_lane[N][0].neg,
		out_e_x == $signed(mtim_pkg::SAT_POS), "overflowed lane not saturated")

endmodule

`default_nettype wire

/* hdl/mtim_div_stage.sv */
// one registered restoring division step for all six output lanes
// depends on mtim_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtim_div_stage (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire mtim_pkg::ctrl_t                        ctrl_d,
	input  wire logic [63:0]                            dm_d,
	input  wire mtim_pkg::lane_t [mtim_pkg::LANES-1:0]  lane_d,
	output mtim_pkg::ctrl_t                             ctrl_q,
	output logic [63:0]                                 dm_q,
	output mtim_pkg::lane_t [mtim_pkg::LANES-1:0]       lane_q
);

	mtim_pkg::lane_t [mtim_pkg::LANES-1:0] nxt;
	logic [65:0] diff [mtim_pkg::LANES];

	always_comb begin
		for (int i = 0; i < mtim_pkg::LANES; i++) begin
			diff[i] = {1'b0, lane_d[i].rem, lane_d[i].low[31]} - {2'b00, dm_d};
			nxt[i] = lane_d[i];
			nxt[i].low = {lane_d[i].low[30:0], 1'b0};
			if (!diff[i][65]) begin
				nxt[i].rem = diff[i][63:0];
				nxt[i].quo = {lane_d[i].quo[30:0], 1'b1};
			end else begin
				nxt[i].rem = {lane_d[i].rem[62:0], lane_d[i].low[31]};
				nxt[i].quo = {lane_d[i].quo[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_q <= dm_d;
			lane_q <= nxt;
		end
	end

endmodule

`default_nettype wire
